// ===== hw/rtl/lwp_pkg.sv =====
// Package for the LCD window pixel writer: item types, command codes and
// the window record shared between modules. Depends on nothing.
package lwp_pkg;

	// Command bytes recognized on the serial link.
	localparam logic [7:0] OP_COLUMN_SET = 8'h2A;
	localparam logic [7:0] OP_ROW_SET    = 8'h2B;
	localparam logic [7:0] OP_MEM_WRITE  = 8'h2C;
	localparam logic [7:0] OP_SHAPE      = 8'h36;

	// Bit of the orientation argument that selects the wide shape (0x20).
	localparam int SHAPE_WIDE_BIT = 5;

	// Argument bytes of a column or row set, and the index of the last one.
	localparam logic [2:0] ARG_COUNT = 3'd4;
	localparam logic [2:0] ARG_LAST  = 3'd3;

	// Active command, one-hot.
	typedef enum logic [4:0] {
		CMD_NONE     = 5'b00001,
		CMD_COLUMN   = 5'b00010,
		CMD_ROW      = 5'b00100,
		CMD_SHAPE    = 5'b01000,
		CMD_MEMWRITE = 5'b10000
	} cmd_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} byte_item_t;

	typedef struct packed {
		logic        pixel_write;
		logic [16:0] pixel_address;
		logic [15:0] pixel_value;
		logic        frame_done;
		logic        landscape;
	} pixel_item_t;

	typedef struct packed {
		logic [15:0] column_start;
		logic [15:0] column_end;
		logic [15:0] row_start;
		logic [15:0] row_end;
		logic        wide;
	} window_t;

	// Control from the command tracker to the pixel path.
	typedef struct packed {
		cmd_t command;
		logic win_reset;
	} ctrl_t;

endpackage

// ===== hw/rtl/lwp_stream_if.sv =====
// Valid/ready stream interface used for both channels of the pixel writer.
// The payload type is a parameter; types come from lwp_pkg.
interface lwp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lwp_window.sv =====
// Command tracker of the pixel writer: active command, argument gathering,
// the column/row window and the panel shape. Depends on lwp_pkg.
module lwp_window #(
	parameter int PANEL_LONG  = 320,
	parameter int PANEL_SHORT = 240
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  lwp_pkg::byte_item_t item,
	output lwp_pkg::window_t   win,
	output lwp_pkg::ctrl_t     ctrl,
	output logic               landscape_next
);

	localparam logic [15:0] LONG_END  = 16'(PANEL_LONG - 1);
	localparam logic [15:0] SHORT_END = 16'(PANEL_SHORT - 1);

	lwp_pkg::cmd_t    cmd_q, cmd_d;
	logic [2:0]       cnt_q, cnt_d;
	logic [7:0]       arg_q [3];
	lwp_pkg::window_t win_q, win_d;
	logic             wr_arg;
	logic             win_reset;

	always_comb begin
		cmd_d     = cmd_q;
		cnt_d     = cnt_q;
		win_d     = win_q;
		wr_arg    = 1'b0;
		win_reset = 1'b0;
		if (step) begin
			if (!item.mode) begin
				unique case (item.data_byte)
					lwp_pkg::OP_COLUMN_SET: begin
						cmd_d = lwp_pkg::CMD_COLUMN;
						cnt_d = '0;
					end
					lwp_pkg::OP_ROW_SET: begin
						cmd_d = lwp_pkg::CMD_ROW;
						cnt_d = '0;
					end
					lwp_pkg::OP_SHAPE: begin
						cmd_d = lwp_pkg::CMD_SHAPE;
						cnt_d = '0;
					end
					lwp_pkg::OP_MEM_WRITE: begin
						cmd_d = lwp_pkg::CMD_MEMWRITE;
					end
					default: begin
						cmd_d = lwp_pkg::CMD_NONE;
					end
				endcase
			end else begin
				unique case (cmd_q)
					lwp_pkg::CMD_COLUMN, lwp_pkg::CMD_ROW: begin
						if (cnt_q < lwp_pkg::ARG_COUNT) begin
							cnt_d = cnt_q + 3'd1;
							if (cnt_q == lwp_pkg::ARG_LAST) begin
								if (cmd_q == lwp_pkg::CMD_COLUMN) begin
									win_d.column_start = {arg_q[0], arg_q[1]};
									win_d.column_end   = {arg_q[2], item.data_byte};
								end else begin
									win_d.row_start = {arg_q[0], arg_q[1]};
									win_d.row_end   = {arg_q[2], item.data_byte};
								end
							end else begin
								wr_arg = 1'b1;
							end
						end
					end
					lwp_pkg::CMD_SHAPE: begin
						if (cnt_q == '0) begin
							cnt_d              = 3'd1;
							win_reset          = 1'b1;
							win_d.wide         = item.data_byte[lwp_pkg::SHAPE_WIDE_BIT];
							win_d.column_start = '0;
							win_d.row_start    = '0;
							win_d.column_end   = win_d.wide ? LONG_END : SHORT_END;
							win_d.row_end      = win_d.wide ? SHORT_END : LONG_END;
						end
					end
					lwp_pkg::CMD_NONE, lwp_pkg::CMD_MEMWRITE: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q              <= lwp_pkg::CMD_NONE;
			cnt_q              <= '0;
			win_q.column_start <= '0;
			win_q.row_start    <= '0;
			win_q.column_end   <= LONG_END;
			win_q.row_end      <= SHORT_END;
			win_q.wide         <= 1'b1;
		end else begin
			cmd_q <= cmd_d;
			cnt_q <= cnt_d;
			win_q <= win_d;
		end
	end

	// Argument bytes are always written before they are read.
	always_ff @(posedge clk) begin
		if (wr_arg) begin
			arg_q[cnt_q[1:0]] <= item.data_byte;
		end
	end

	assign win            = win_q;
	assign ctrl.command   = cmd_q;
	assign ctrl.win_reset = win_reset;
	assign landscape_next = win_d.wide;

endmodule

// ===== hw/rtl/lwp_pixel.sv =====
// Pixel path of the pixel writer: byte pairing, write cursor, pixel count
// and the address/value of each pixel. Depends on lwp_pkg.
module lwp_pixel #(
	parameter int PANEL_LONG  = 320,
	parameter int PANEL_SHORT = 240
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  lwp_pkg::byte_item_t  item,
	input  lwp_pkg::window_t    win,
	input  lwp_pkg::ctrl_t      ctrl,
	output logic                pixel_write,
	output logic [16:0]         pixel_address,
	output logic [15:0]         pixel_value,
	output logic                frame_done
);

	localparam int PMAX = (PANEL_LONG > PANEL_SHORT) ? PANEL_LONG : PANEL_SHORT;
	localparam int PW   = $clog2(PMAX + 1);
	localparam int AW   = 16 + PW + 1;

	localparam logic [PW-1:0] LONG_W  = PW'(PANEL_LONG);
	localparam logic [PW-1:0] SHORT_W = PW'(PANEL_SHORT);

	logic [15:0]   col_q, col_d, row_q, row_d;
	logic [32:0]   left_q, left_d;
	logic          held_q, held_d;
	logic [7:0]    hi_q;
	logic          take_hi;

	logic [PW-1:0] width, height;
	logic [15:0]   width16, height16;
	logic [16:0]   span_col, span_row;
	logic [33:0]   area;
	logic [AW-1:0] addr_full;
	logic          in_window;
	logic [15:0]   col_inc, row_inc;

	assign width    = win.wide ? LONG_W : SHORT_W;
	assign height   = win.wide ? SHORT_W : LONG_W;
	assign width16  = 16'(width);
	assign height16 = 16'(height);

	assign span_col  = {1'b0, win.column_end} - {1'b0, win.column_start} + 17'd1;
	assign span_row  = {1'b0, win.row_end} - {1'b0, win.row_start} + 17'd1;
	assign area      = span_col * span_row;
	assign addr_full = AW'(row_q * width) + AW'(col_q);
	assign in_window = (col_q < width16) && (row_q < height16)
		&& (col_q <= win.column_end) && (row_q <= win.row_end);
	assign col_inc   = col_q + 16'd1;
	assign row_inc   = row_q + 16'd1;

	always_comb begin
		col_d         = col_q;
		row_d         = row_q;
		left_d        = left_q;
		held_d        = held_q;
		take_hi       = 1'b0;
		pixel_write   = 1'b0;
		pixel_address = '0;
		pixel_value   = '0;
		frame_done    = 1'b0;
		if (step) begin
			if (!item.mode) begin
				if (item.data_byte == lwp_pkg::OP_MEM_WRITE) begin
					col_d  = win.column_start;
					row_d  = win.row_start;
					held_d = 1'b0;
					if (win.column_end < win.column_start || win.row_end < win.row_start) begin
						left_d = '0;
					end else begin
						left_d = area[32:0];
					end
				end
			end else if (ctrl.win_reset) begin
				col_d  = '0;
				row_d  = '0;
				held_d = 1'b0;
				left_d = '0;
			end else if (ctrl.command == lwp_pkg::CMD_MEMWRITE) begin
				if (!held_q) begin
					take_hi = 1'b1;
					held_d  = 1'b1;
				end else begin
					held_d = 1'b0;
					if (in_window) begin
						pixel_write   = 1'b1;
						pixel_address = addr_full[16:0];
						pixel_value   = {hi_q, item.data_byte};
					end
					if (left_q != '0) begin
						left_d     = left_q - 33'd1;
						frame_done = (left_q == 33'd1);
					end
					// Advance along the row, then wrap to the next row inside the window.
					col_d = col_inc;
					if (col_inc > win.column_end) begin
						col_d = win.column_start;
						row_d = row_inc;
						if (row_inc > win.row_end) begin
							row_d = win.row_start;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
			held_q <= 1'b0;
		end else begin
			col_q  <= col_d;
			row_q  <= row_d;
			left_q <= left_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take_hi) begin
			hi_q <= item.data_byte;
		end
	end

endmodule

// ===== hw/rtl/lcd_window_pixel_writer_unit.sv =====
// Top level of the LCD window pixel writer: input register, command tracker,
// pixel path and result register. Depends on lwp_pkg, lwp_stream_if,
// lwp_window and lwp_pixel.
//
//   Channel        Dir  Payload                                      Per request
//   byte_stream    in   mode, data_byte                              one serial byte
//   pixel_stream   out  pixel_write, pixel_address, pixel_value,     one result
//                       frame_done, landscape
//
// Every byte request gives exactly one result request. A byte sits in the
// input register, where its state update and result are computed; both are
// registered together, into the state registers and the result register,
// when the byte moves on, so the result is offered from the result register.
// A new byte is taken every cycle while the result register is not stalled;
// the rate is set by the state update, which holds one 17x17 multiplier for
// the window area and one 16xPW multiplier for the pixel address. When the
// result register is held by a stall, one more byte is still taken into the
// input register. Reset restores the full landscape window, clears the cursor
// and pixel count, and empties both registers; no clearing pass is needed.
module lcd_window_pixel_writer_unit #(
	parameter int PANEL_LONG  = 320,
	parameter int PANEL_SHORT = 240
) (
	input logic clk,
	input logic arst_n,
	lwp_stream_if.sink   byte_stream,
	lwp_stream_if.source pixel_stream
);

	// Input register.
	logic                valid_s1;
	lwp_pkg::byte_item_t item_s1;

	// Result register.
	logic                 out_valid_q;
	lwp_pkg::pixel_item_t out_item_q;

	logic                 advance;
	lwp_pkg::window_t     win;
	lwp_pkg::ctrl_t       ctrl;
	logic                 landscape_next;
	lwp_pkg::pixel_item_t result;

	// The held byte moves on when the result register is empty or being drained.
	assign advance           = valid_s1 && (!out_valid_q || pixel_stream.ready);
	assign byte_stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.ready && byte_stream.valid) begin
			item_s1 <= byte_stream.payload;
		end
	end

	// The command tracker owns the window and the shape; the pixel path sees
	// the window as it stood before this byte.
	lwp_window #(
		.PANEL_LONG (PANEL_LONG),
		.PANEL_SHORT(PANEL_SHORT)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.win           (win),
		.ctrl          (ctrl),
		.landscape_next(landscape_next)
	);

	lwp_pixel #(
		.PANEL_LONG (PANEL_LONG),
		.PANEL_SHORT(PANEL_SHORT)
	) u_pixel (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.item         (item_s1),
		.win          (win),
		.ctrl         (ctrl),
		.pixel_write  (result.pixel_write),
		.pixel_address(result.pixel_address),
		.pixel_value  (result.pixel_value),
		.frame_done   (result.frame_done)
	);

	// The shape reported is the one in force after this byte.
	assign result.landscape = landscape_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pixel_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

	assign pixel_stream.valid   = out_valid_q;
	assign pixel_stream.payload = out_item_q;

	// A result appears only for a byte that was held in the input register.
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a byte in the input register");

	// A result that writes nothing carries a zero address and value.
	a_idle_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_item_q.pixel_write)
			|-> (out_item_q.pixel_address == '0 && out_item_q.pixel_value == '0))
		else $error("non-write result carries address or value");

	// A byte that cannot move on stays in the input register unchanged.
	a_held_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled byte lost or changed");

	// While the result register is stalled, its content does not change.
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pixel_stream.ready) |=> (out_valid_q && $stable(out_item_q)))
		else $error("stalled result lost or changed");

endmodule
